// ===== rtl/core/ilfr_pkg.sv =====
// package for the idle-line frame ring: payload structs, item kinds and sizing defaults
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ilfr_pkg;

    localparam int ILFR_STORE_BYTES = 256;
    localparam int ILFR_MAX_FRAME   = 64;
    localparam int ILFR_SLOTS       = 8;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int KIND_W   = 2;
    localparam int READ_CAP = 64;

    localparam logic [KIND_W-1:0] KIND_RX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] rx_byte;
        logic [LEN_W-1:0]  max_len;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [LEN_W-1:0]  frame_len;
        logic              found;
        logic              last;
    } result_t;

    // everything of a result except the byte, which the store delivers in the cycle after the push
    typedef struct packed {
        logic [LEN_W-1:0] frame_len;
        logic             found;
        logic             last;
        logic             use_mem;
    } push_t;

endpackage

// ===== rtl/core/ilfr_out_buf.sv =====
// result buffer: joins store read data with its result fields, two-entry skid toward the output
// depends on ilfr_pkg
`timescale 1ns / 1ps

module ilfr_out_buf
    import ilfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  push_t   push_meta,
    input  logic [DATA_W-1:0] mem_byte,
    output logic    credit,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    pend_reg, pend_next;
    push_t   pend_meta_reg, pend_meta_next;
    logic    hold_valid_reg, hold_valid_next;
    result_t hold_reg, hold_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic    take;
    logic    out_free;
    result_t pend_item;
    logic [1:0] occ;

    assign take     = out_valid_reg && !result_stall;
    assign out_free = !out_valid_reg || take;

    assign pend_item.data_byte = pend_meta_reg.use_mem ? mem_byte : '0;
    assign pend_item.frame_len = pend_meta_reg.frame_len;
    assign pend_item.found     = pend_meta_reg.found;
    assign pend_item.last      = pend_meta_reg.last;

    // entries in flight once this cycle's transaction leaves; at most two may be owed
    assign occ    = 2'(out_valid_reg) + 2'(hold_valid_reg) + 2'(pend_reg) - 2'(take);
    assign credit = (occ < 2'd2);

    always_comb
    begin
        pend_next       = push;
        pend_meta_next  = push_meta;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = hold_reg;
                if (pend_reg)
                begin
                    hold_next = pend_item;
                end
                else
                begin
                    hold_valid_next = 1'b0;
                end
            end
            else if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_item;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (pend_reg)
        begin
            hold_valid_next = 1'b1;
            hold_next       = pend_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_meta_reg <= pend_meta_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/core/idle_line_frame_ring_top.sv =====
// idle-line frame ring: byte store, descriptor ring and read sequencer
// depends on ilfr_pkg and ilfr_out_buf
`timescale 1ns / 1ps

// Receive-side frame store for a serial link.
// item channel (item_valid/item_stall/item): kind RX writes rx_byte into the current
// frame, kind IDLE closes the frame into the descriptor ring, kind READ pops the
// oldest frame and returns up to max_len (at most 64) of its bytes. kind 3 is ignored.
// result channel (result_valid/result_stall/result): one transaction per byte read,
// last marks the final one; an empty ring or a zero-length read gives a single result.
// RX and IDLE never stall the item channel, so bytes may arrive back to back.
// A READ stalls the item channel while its descriptor is read and its bytes issued;
// the byte store streams one byte per cycle while the output buffer has credit, and
// the descriptor ring read is registered. A first byte passes the ring read, the
// store read and the output buffer; an empty ring or zero-length read skips the store.
// Reset clears the ring pointers and the frame counters; the memories hold no reset
// value and need no clearing pass, so items are taken right after reset.
// When the receiver stalls, results wait in a two-entry output buffer and the store
// reads pause; item_stall stays high until every byte read of a READ is issued.

module idle_line_frame_ring_top
    import ilfr_pkg::*;
#(
    parameter int STORE_BYTES = ILFR_STORE_BYTES,
    parameter int MAX_FRAME   = ILFR_MAX_FRAME,
    parameter int SLOTS       = ILFR_SLOTS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SUM_W  = $clog2(STORE_BYTES + MAX_FRAME + 1);
    localparam int DESC_W = ADDR_W + CNT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DESC   = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [ADDR_W-1:0] frame_start_reg, frame_start_next;
    logic [CNT_W-1:0]  frame_count_reg, frame_count_next;
    logic [LEN_W-1:0]  want_reg, want_next;
    logic              empty_reg, empty_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // memories
    logic [DATA_W-1:0] byte_mem [STORE_BYTES];
    logic [DESC_W-1:0] ring_mem [SLOTS];
    logic [DATA_W-1:0] byte_rdata_reg;
    logic [DESC_W-1:0] ring_rdata_reg;

    logic              byte_we, byte_re, ring_we, ring_re;
    logic [ADDR_W-1:0] byte_waddr;
    logic [DESC_W-1:0] ring_wdata;

    logic              accept;
    logic              push;
    push_t             push_meta;
    logic              credit;

    logic [ADDR_W:0]   wsum;
    logic [SUM_W-1:0]  fsum;
    logic [ADDR_W-1:0] fill_next;
    logic [ADDR_W-1:0] desc_start;
    logic [CNT_W-1:0]  desc_len;
    logic [LEN_W-1:0]  read_len;
    logic [LEN_W-1:0]  max_clamped;
    logic [SLOT_W:0]   wslot_inc, rslot_inc;
    logic [SLOT_W-1:0] wslot_step, rslot_step;
    logic [ADDR_W:0]   addr_inc;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // byte address of the current frame, wrapped around the store
    assign wsum       = {1'b0, frame_start_reg} + (ADDR_W + 1)'(frame_count_reg);
    assign byte_waddr = (wsum >= (ADDR_W + 1)'(STORE_BYTES))
                      ? ADDR_W'(wsum - (ADDR_W + 1)'(STORE_BYTES)) : wsum[ADDR_W-1:0];

    // next fill offset; wraps to zero when less than one full frame of space is left
    assign fsum      = SUM_W'(frame_start_reg) + SUM_W'(frame_count_reg);
    assign fill_next = (fsum > SUM_W'(STORE_BYTES - MAX_FRAME)) ? '0 : fsum[ADDR_W-1:0];

    assign wslot_inc  = (SLOT_W + 1)'(write_slot_reg) + 1'b1;
    assign wslot_step = (wslot_inc >= (SLOT_W + 1)'(SLOTS - 1)) ? '0 : wslot_inc[SLOT_W-1:0];
    assign rslot_inc  = (SLOT_W + 1)'(read_slot_reg) + 1'b1;
    assign rslot_step = (rslot_inc >= (SLOT_W + 1)'(SLOTS - 1)) ? '0 : rslot_inc[SLOT_W-1:0];

    assign max_clamped = (item.max_len > LEN_W'(READ_CAP)) ? LEN_W'(READ_CAP) : item.max_len;

    assign desc_start = ring_rdata_reg[CNT_W +: ADDR_W];
    assign desc_len   = ring_rdata_reg[CNT_W-1:0];
    assign read_len   = (LEN_W'(desc_len) > want_reg) ? want_reg : LEN_W'(desc_len);

    assign addr_inc   = {1'b0, addr_reg} + 1'b1;
    assign ring_wdata = {frame_start_reg, frame_count_reg};

    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        read_slot_next   = read_slot_reg;
        frame_start_next = frame_start_reg;
        frame_count_next = frame_count_reg;
        want_next        = want_reg;
        empty_next       = empty_reg;
        addr_next        = addr_reg;
        rem_next         = rem_reg;
        len_next         = len_reg;
        byte_we          = 1'b0;
        byte_re          = 1'b0;
        ring_we          = 1'b0;
        ring_re          = 1'b0;
        push             = 1'b0;
        push_meta        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        KIND_RX:
                        begin
                            if (frame_count_reg < CNT_W'(MAX_FRAME))
                            begin
                                byte_we          = 1'b1;
                                frame_count_next = frame_count_reg + 1'b1;
                            end
                        end
                        KIND_IDLE:
                        begin
                            ring_we          = 1'b1;
                            write_slot_next  = wslot_step;
                            frame_start_next = fill_next;
                            frame_count_next = '0;
                        end
                        KIND_READ:
                        begin
                            // descriptor arrives next cycle; the ring write of an
                            // earlier close has already landed, so no forwarding
                            ring_re    = 1'b1;
                            want_next  = max_clamped;
                            empty_next = (read_slot_reg == write_slot_reg);
                            state_next = S_DESC;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DESC:
            begin
                if (!empty_reg && read_len != '0)
                begin
                    read_slot_next = rslot_step;
                    addr_next      = desc_start;
                    rem_next       = read_len;
                    len_next       = read_len;
                    state_next     = S_STREAM;
                end
                else if (credit)
                begin
                    // empty ring or zero-length read: one result with no byte
                    push              = 1'b1;
                    push_meta.found   = !empty_reg;
                    push_meta.last    = 1'b1;
                    if (!empty_reg)
                    begin
                        read_slot_next = rslot_step;
                    end
                    state_next = S_IDLE;
                end
            end
            S_STREAM:
            begin
                if (credit)
                begin
                    byte_re             = 1'b1;
                    push                = 1'b1;
                    push_meta.frame_len = len_reg;
                    push_meta.found     = 1'b1;
                    push_meta.last      = (rem_reg == LEN_W'(1));
                    push_meta.use_mem   = 1'b1;
                    addr_next = (addr_inc == (ADDR_W + 1)'(STORE_BYTES))
                              ? '0 : addr_inc[ADDR_W-1:0];
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            frame_start_reg <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            read_slot_reg   <= read_slot_next;
            frame_start_reg <= frame_start_next;
            frame_count_reg <= frame_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg  <= want_next;
        empty_reg <= empty_next;
        addr_reg  <= addr_next;
        rem_reg   <= rem_next;
        len_reg   <= len_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= item.rx_byte;
        end
        if (byte_re)
        begin
            byte_rdata_reg <= byte_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[write_slot_reg] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rdata_reg <= ring_mem[read_slot_reg];
        end
    end

    ilfr_out_buf u_out_buf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_meta    (push_meta),
        .mem_byte     (byte_rdata_reg),
        .credit       (credit),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/core/ilfr_checker.sv =====
// port-level checks of the idle-line frame ring, bound to the top level
// depends on ilfr_pkg and idle_line_frame_ring_top
`timescale 1ns / 1ps

module ilfr_checker
    import ilfr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // an empty-ring read is a single closing result with no data
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |->
            result.last && result.frame_len == '0 && result.data_byte == '0)
    else $error("bad empty-ring result");

    // a result that is not the last belongs to a non-empty frame read
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.found && result.frame_len != '0)
    else $error("non-final result without frame");

    // a read holds off the item channel while its descriptor is fetched
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.kind == KIND_READ |=> item_stall)
    else $error("item taken during read");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.frame_len <= LEN_W'(READ_CAP))
    else $error("frame_len above cap");

endmodule

bind idle_line_frame_ring_top ilfr_checker u_ilfr_checker (.*);
